[rtl/h_bridge_pwm_drive_sequencer_assert.svh]
// Assertion helpers for the H-bridge drive sequencer.
// Each expects clk and rst_n in scope and is checked out of reset.
`ifndef H_BRIDGE_PWM_DRIVE_SEQUENCER_ASSERT_SVH
`define H_BRIDGE_PWM_DRIVE_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define HBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hbs_pkg.sv]
package hbs_pkg;

  // command codes
  localparam logic [1:0] ACT_DRIVE_ALL = 2'd0;
  localparam logic [1:0] ACT_DRIVE_ONE = 2'd1;
  localparam logic [1:0] ACT_BRAKE_ALL = 2'd2;
  localparam logic [1:0] ACT_COAST_ALL = 2'd3;

  // stored channel direction
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // register indexes
  localparam logic CFG_PERIOD    = 1'b0;
  localparam logic CFG_SIGN_MASK = 1'b1;

  localparam int PERIOD_W = 17;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 17'd65536;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 17'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd1000;

  typedef struct packed {
    logic [1:0]          action;
    logic signed [15:0]  front_left_speed;
    logic signed [15:0]  front_right_speed;
    logic signed [15:0]  rear_left_speed;
    logic signed [15:0]  rear_right_speed;
    logic [1:0]          motor_index;
    logic signed [15:0]  single_speed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          channel;
    logic                in1_level;
    logic                in2_level;
    logic [PERIOD_W-1:0] compare_value;
    logic                commit_update;
    logic                hold_period;
    logic                last;
  } out_item_t;

  // one channel update before compare scaling
  typedef struct packed {
    logic [1:0] channel;
    logic       in1_level;
    logic       in2_level;
    logic       commit_update;
    logic       hold_period;
    logic       last;
  } desc_t;

  // bridge pins {in1, in2} for a drive direction; stopped means brake
  function automatic logic [1:0] pins_of(input logic [1:0] dir);
    logic [1:0] pins;
    case (dir)
      DIR_FWD: pins = 2'b01;
      DIR_REV: pins = 2'b10;
      default: pins = 2'b11;
    endcase
    return pins;
  endfunction

endpackage

[rtl/hbs_planner.sv]
`include "h_bridge_pwm_drive_sequencer_assert.svh"

module hbs_planner #(
  parameter int MAX_COMMAND = 1000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  hbs_pkg::in_item_t                  in_data,
  input  logic [3:0]                         sign_invert_mask,
  input  logic                               adv,
  output logic                               desc_vld_r,
  output hbs_pkg::desc_t                     desc_r,
  output logic [$clog2(MAX_COMMAND+1)-1:0]   desc_mag_r
);

  localparam int MAG_W = $clog2(MAX_COMMAND + 1);
  localparam logic [MAG_W-1:0] MAG_MAX   = MAG_W'(MAX_COMMAND);
  localparam logic [16:0]      MAG_MAX_W = 17'(MAX_COMMAND);

  logic signed [15:0] speed [4];
  logic [1:0]         new_dir [4];
  logic [MAG_W-1:0]   new_mag [4];
  logic [1:0]         dir_r [4];
  logic [1:0]         one_dir;
  logic               change_all;
  logic               one_brake;
  logic               accept;

  // loaded command
  logic               plan_vld_r;
  logic [1:0]         plan_act_r;
  logic               plan_brake_r;
  logic [1:0]         plan_ch_r;
  logic [1:0]         plan_dir_r [4];
  logic [MAG_W-1:0]   plan_mag_r [4];
  logic [2:0]         step_r;

  logic               is_one;
  logic [2:0]         nb;
  logic [2:0]         nd;
  logic [2:0]         last_idx;
  logic               in_brake;
  logic [1:0]         j;
  logic [1:0]         idx;
  hbs_pkg::desc_t     desc_nxt;
  logic [MAG_W-1:0]   mag_nxt;

  always_comb begin
    speed[0] = in_data.front_right_speed;
    speed[1] = in_data.rear_left_speed;
    speed[2] = in_data.front_left_speed;
    speed[3] = in_data.rear_right_speed;
  end

  for (genvar i = 0; i < 4; i++) begin : gen_ch
    logic signed [15:0] sp;
    logic               inv;
    logic [16:0]        abs_v;

    assign sp    = (in_data.action == hbs_pkg::ACT_DRIVE_ONE) ? in_data.single_speed
                                                              : speed[i];
    assign inv   = (in_data.action == hbs_pkg::ACT_DRIVE_ALL) & sign_invert_mask[i];
    // -32768 gives 32768, hence 17 bits
    assign abs_v = sp[15] ? (17'd0 - {sp[15], sp}) : {1'b0, sp};
    assign new_mag[i] = (abs_v > MAG_MAX_W) ? MAG_MAX : abs_v[MAG_W-1:0];
    assign new_dir[i] = (sp == 16'sd0) ? hbs_pkg::DIR_STOP :
                        ((sp[15] ^ inv) ? hbs_pkg::DIR_REV : hbs_pkg::DIR_FWD);
  end

  // drive-one computes the same direction on every lane
  assign one_dir   = new_dir[in_data.motor_index];
  assign one_brake = (one_dir != hbs_pkg::DIR_STOP) &&
                     (dir_r[in_data.motor_index] != one_dir);

  always_comb begin
    change_all = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (new_dir[i] != dir_r[i]) change_all = 1'b1;
    end
  end

  // result count: brake group then drive group
  assign is_one = (plan_act_r == hbs_pkg::ACT_DRIVE_ONE);
  assign nb     = plan_brake_r ? (is_one ? 3'd1 : 3'd4) : 3'd0;

  always_comb begin
    case (plan_act_r)
      hbs_pkg::ACT_DRIVE_ALL: nd = 3'd4;
      hbs_pkg::ACT_DRIVE_ONE: nd = 3'd1;
      hbs_pkg::ACT_BRAKE_ALL: nd = 3'd0;
      default:                nd = 3'd4;
    endcase
  end

  assign last_idx = nb + nd - 3'd1;
  assign in_brake = (step_r < nb);
  assign j        = 2'(step_r - nb);
  assign idx      = is_one ? plan_ch_r : j;

  always_comb begin
    desc_nxt = '0;
    mag_nxt  = '0;
    if (in_brake) begin
      desc_nxt.channel       = is_one ? plan_ch_r : step_r[1:0];
      desc_nxt.in1_level     = 1'b1;
      desc_nxt.in2_level     = 1'b1;
      desc_nxt.commit_update = is_one | (step_r[1:0] == 2'd3);
      desc_nxt.hold_period   = is_one |
                               ((step_r[1:0] == 2'd3) && (plan_act_r == hbs_pkg::ACT_DRIVE_ALL));
      desc_nxt.last          = (plan_act_r == hbs_pkg::ACT_BRAKE_ALL) && (step_r[1:0] == 2'd3);
    end else begin
      desc_nxt.channel = idx;
      case (plan_act_r)
        hbs_pkg::ACT_DRIVE_ALL: begin
          {desc_nxt.in1_level, desc_nxt.in2_level} = hbs_pkg::pins_of(plan_dir_r[idx]);
          mag_nxt                = plan_mag_r[idx];
          desc_nxt.commit_update = (j == 2'd3);
          desc_nxt.last          = (j == 2'd3);
        end
        hbs_pkg::ACT_DRIVE_ONE: begin
          {desc_nxt.in1_level, desc_nxt.in2_level} = hbs_pkg::pins_of(plan_dir_r[idx]);
          mag_nxt       = plan_mag_r[idx];
          desc_nxt.last = 1'b1;
        end
        hbs_pkg::ACT_COAST_ALL: begin
          // full-scale magnitude scales to exactly the period
          mag_nxt       = MAG_MAX;
          desc_nxt.last = (j == 2'd3);
        end
        default: begin
          desc_nxt.in1_level = 1'b1;
          desc_nxt.in2_level = 1'b1;
        end
      endcase
    end
  end

  assign in_ready = !plan_vld_r || (adv && (step_r == last_idx));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) dir_r[i] <= hbs_pkg::DIR_STOP;
    end else if (accept) begin
      case (in_data.action)
        hbs_pkg::ACT_DRIVE_ALL: begin
          for (int i = 0; i < 4; i++) dir_r[i] <= new_dir[i];
        end
        hbs_pkg::ACT_DRIVE_ONE: begin
          dir_r[in_data.motor_index] <= one_dir;
        end
        default: begin
          for (int i = 0; i < 4; i++) dir_r[i] <= hbs_pkg::DIR_STOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_vld_r <= 1'b0;
      step_r     <= 3'd0;
    end else if (accept) begin
      plan_vld_r <= 1'b1;
      step_r     <= 3'd0;
    end else if (plan_vld_r && adv) begin
      if (step_r == last_idx) begin
        plan_vld_r <= 1'b0;
      end else begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan_act_r <= in_data.action;
      plan_ch_r  <= in_data.motor_index;
      case (in_data.action)
        hbs_pkg::ACT_DRIVE_ALL: plan_brake_r <= change_all;
        hbs_pkg::ACT_DRIVE_ONE: plan_brake_r <= one_brake;
        default:                plan_brake_r <= 1'b1;
      endcase
      for (int i = 0; i < 4; i++) begin
        plan_dir_r[i] <= new_dir[i];
        plan_mag_r[i] <= new_mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_vld_r <= 1'b0;
    end else if (adv) begin
      desc_vld_r <= plan_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      desc_r     <= desc_nxt;
      desc_mag_r <= mag_nxt;
    end
  end

  `HBS_ASSERT_NOW(a_step_in_range, plan_vld_r, step_r <= last_idx, "step past end of command")
  `HBS_ASSERT_NEXT(a_last_marked, plan_vld_r && adv && (step_r == last_idx),
                   desc_vld_r && desc_r.last, "final update of command not marked last")

endmodule

[rtl/hbs_scale.sv]
`include "h_bridge_pwm_drive_sequencer_assert.svh"

module hbs_scale #(
  parameter int MAX_COMMAND = 1000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               desc_vld,
  input  hbs_pkg::desc_t                     desc,
  input  logic [$clog2(MAX_COMMAND+1)-1:0]   desc_mag,
  input  logic [hbs_pkg::PERIOD_W-1:0]       period_cnt,
  output logic                               out_valid_r,
  output hbs_pkg::out_item_t                 out_data_r
);

  localparam int PW    = hbs_pkg::PERIOD_W;
  localparam int MAG_W = $clog2(MAX_COMMAND + 1);
  localparam int X_W   = MAG_W + PW;
  // MAX_COMMAND >= 2**(MAG_W-1), so the reciprocal needs PW+2 bits
  localparam int K_W   = PW + 2;
  localparam logic [K_W-1:0] RECIP = K_W'((64'd1 << X_W) / MAX_COMMAND);
  localparam logic [X_W-1:0] MAX_X = X_W'(MAX_COMMAND);
  localparam logic [X_W:0]   TWO_M = (X_W + 1)'(2 * MAX_COMMAND);

  // stage 2: magnitude times period
  logic               v2_r;
  hbs_pkg::desc_t     d2_r;
  logic [X_W-1:0]     x2_r;
  // stage 3: quotient estimate, low by at most one
  logic               v3_r;
  hbs_pkg::desc_t     d3_r;
  logic [X_W-1:0]     x3_r;
  logic [PW-1:0]      q3_r;
  logic [X_W+K_W-1:0] prod3;
  // output: remainder check
  logic [X_W-1:0]     qm;
  logic [X_W-1:0]     rem;
  logic [PW-1:0]      q_fix;

  assign prod3 = {{K_W{1'b0}}, x2_r} * {{X_W{1'b0}}, RECIP};
  assign qm    = {{MAG_W{1'b0}}, q3_r} * MAX_X;
  assign rem   = x3_r - qm;
  assign q_fix = (rem >= MAX_X) ? (q3_r + 17'd1) : q3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v2_r        <= desc_vld;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_r <= desc;
      x2_r <= {{PW{1'b0}}, desc_mag} * {{MAG_W{1'b0}}, period_cnt};
      d3_r <= d2_r;
      x3_r <= x2_r;
      q3_r <= prod3[X_W +: PW];
      out_data_r.channel       <= d3_r.channel;
      out_data_r.in1_level     <= d3_r.in1_level;
      out_data_r.in2_level     <= d3_r.in2_level;
      out_data_r.compare_value <= q_fix;
      out_data_r.commit_update <= d3_r.commit_update;
      out_data_r.hold_period   <= d3_r.hold_period;
      out_data_r.last          <= d3_r.last;
    end
  end

  `HBS_ASSERT_NOW(a_rem_bounded, v3_r, rem < TWO_M, "quotient estimate off by more than one")
  `HBS_ASSERT_NOW(a_brake_zero, out_valid_r && out_data_r.in1_level && out_data_r.in2_level,
                  out_data_r.compare_value == 17'd0, "brake update with nonzero compare")
  `HBS_ASSERT_NEXT(a_stage_moves, v3_r && adv, out_valid_r, "update lost at output stage")

endmodule

[rtl/h_bridge_pwm_drive_sequencer.sv]
// Four-channel H-bridge drive sequencer.
// in_*  : one command per transfer (drive all, drive one, brake all, coast all).
// out_* : one channel update per transfer: pins, compare count, commit/hold
//         flags and a last marker on the final update of each command.
// cfg_* : register writes (0 PWM period, 1 sign_invert_mask), always ready;
//         write only while no command is in flight.
// A command turns into 1 to 8 updates (8 for coast all or for drive all with
// a direction change), issued one per cycle while the receiver keeps up. The
// next command is taken in the cycle its predecessor issues its last update.
// On its way out, the first update of a command passes the planner's command
// and update registers, then three compare stages (multiply by period,
// reciprocal multiply for the divide by MAX_COMMAND, remainder correction
// into the output register).
// A stalled receiver freezes the whole pipeline and, through it, in_ready;
// nothing is dropped. Synchronous reset stops every channel, empties the
// pipeline and restores a PWM period of 1000 and sign_invert_mask 0.
module h_bridge_pwm_drive_sequencer #(
  parameter int MAX_COMMAND = 1000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hbs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hbs_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [hbs_pkg::PERIOD_W-1:0]  cfg_data
);

  localparam int MAG_W = $clog2(MAX_COMMAND + 1);

  logic [hbs_pkg::PERIOD_W-1:0] period_cnt_r;
  logic [hbs_pkg::PERIOD_W-1:0] period_cnt_nxt;
  logic [3:0]                   sign_invert_mask_r;
  logic                         adv;
  logic                         desc_vld;
  hbs_pkg::desc_t               desc;
  logic [MAG_W-1:0]             desc_mag;

  // pipeline moves whenever the output register is empty or being taken
  assign adv       = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // out-of-range periods are clipped to 1..65536
  always_comb begin
    if (cfg_data == '0) begin
      period_cnt_nxt = hbs_pkg::PERIOD_MIN;
    end else if (cfg_data > hbs_pkg::PERIOD_MAX) begin
      period_cnt_nxt = hbs_pkg::PERIOD_MAX;
    end else begin
      period_cnt_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_cnt_r       <= hbs_pkg::PERIOD_RESET;
      sign_invert_mask_r <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbs_pkg::CFG_PERIOD:    period_cnt_r       <= period_cnt_nxt;
        hbs_pkg::CFG_SIGN_MASK: sign_invert_mask_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // command register, direction state and update sequencing
  hbs_planner #(
    .MAX_COMMAND (MAX_COMMAND)
  ) u_planner (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .sign_invert_mask (sign_invert_mask_r),
    .adv              (adv),
    .desc_vld_r       (desc_vld),
    .desc_r           (desc),
    .desc_mag_r       (desc_mag)
  );

  // compare = magnitude * period / MAX_COMMAND, rounded down
  hbs_scale #(
    .MAX_COMMAND (MAX_COMMAND)
  ) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .desc_vld    (desc_vld),
    .desc        (desc),
    .desc_mag    (desc_mag),
    .period_cnt  (period_cnt_r),
    .out_valid_r (out_valid),
    .out_data_r  (out_data)
  );

endmodule

[tb/sv/hbs_update_checker.sv]
// Watches the command, update and register channels of the drive sequencer,
// predicts every channel update and compares it with what the block sends.
module hbs_update_checker #(
  parameter int MAX_COMMAND = 1000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  hbs_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  hbs_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [hbs_pkg::PERIOD_W-1:0]  cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            cmd_count,
  output int                            update_count
);
  import hbs_pkg::*;

  out_item_t           expected_updates[$];
  logic [PERIOD_W-1:0] period_q;
  logic [3:0]          invert_mask;
  logic [1:0]          chan_dir[4];
  int                  errs;
  int                  cmds;
  int                  updates;

  function automatic logic [1:0] dir_of(input int s);
    if (s > 0) return DIR_FWD;
    if (s < 0) return DIR_REV;
    return DIR_STOP;
  endfunction

  // magnitude clamped to full scale, then scaled to the period, truncated
  function automatic logic [PERIOD_W-1:0] scaled(input int s);
    longint mag;
    mag = (s < 0) ? -s : s;
    if (mag > MAX_COMMAND) mag = MAX_COMMAND;
    return PERIOD_W'((mag * period_q) / MAX_COMMAND);
  endfunction

  function automatic void push_update(input int ch, input logic in1, input logic in2,
                                      input logic [PERIOD_W-1:0] cmp, input logic commit,
                                      input logic hold, input logic fin);
    out_item_t u;
    u.channel       = 2'(ch);
    u.in1_level     = in1;
    u.in2_level     = in2;
    u.compare_value = cmp;
    u.commit_update = commit;
    u.hold_period   = hold;
    u.last          = fin;
    expected_updates.push_back(u);
  endfunction

  function automatic void push_drive(input int ch, input logic [1:0] dir,
                                     input logic [PERIOD_W-1:0] cmp, input logic commit,
                                     input logic fin);
    case (dir)
      DIR_FWD: push_update(ch, 1'b0, 1'b1, cmp, commit, 1'b0, fin);
      DIR_REV: push_update(ch, 1'b1, 1'b0, cmp, commit, 1'b0, fin);
      default: push_update(ch, 1'b1, 1'b1, '0, commit, 1'b0, fin);
    endcase
  endfunction

  // all four channels to brake; commit on the last one
  function automatic void brake_group(input logic hold, input logic fin);
    for (int i = 0; i < 4; i++) begin
      push_update(i, 1'b1, 1'b1, '0, i == 3, (i == 3) && hold, (i == 3) && fin);
      chan_dir[i] = DIR_STOP;
    end
  endfunction

  function automatic void predict_updates(input in_item_t cmd);
    int                  w[4];
    logic [1:0]          d[4];
    logic [PERIOD_W-1:0] c[4];
    logic                turn;
    int                  s;
    int                  ch;
    logic [1:0]          dd;
    case (cmd.action)
      ACT_DRIVE_ALL: begin
        w[0] = int'($signed(cmd.front_right_speed));
        w[1] = int'($signed(cmd.rear_left_speed));
        w[2] = int'($signed(cmd.front_left_speed));
        w[3] = int'($signed(cmd.rear_right_speed));
        turn = 1'b0;
        for (int i = 0; i < 4; i++) begin
          s = w[i];
          if (invert_mask[i]) s = -s;
          if (s > MAX_COMMAND) s = MAX_COMMAND;
          else if (s < -MAX_COMMAND) s = -MAX_COMMAND;
          d[i] = dir_of(s);
          c[i] = scaled(s);
          if (d[i] != chan_dir[i]) turn = 1'b1;
        end
        if (turn) brake_group(1'b1, 1'b0);
        for (int i = 0; i < 4; i++) begin
          push_drive(i, d[i], c[i], i == 3, i == 3);
          chan_dir[i] = d[i];
        end
      end
      ACT_DRIVE_ONE: begin
        ch = int'(cmd.motor_index);
        s  = int'($signed(cmd.single_speed));
        dd = dir_of(s);
        if (dd != DIR_STOP && chan_dir[ch] != dd)
          push_update(ch, 1'b1, 1'b1, '0, 1'b1, 1'b1, 1'b0);
        push_drive(ch, dd, (dd != DIR_STOP) ? scaled(s) : '0, 1'b0, 1'b1);
        chan_dir[ch] = dd;
      end
      ACT_BRAKE_ALL: brake_group(1'b0, 1'b1);
      ACT_COAST_ALL: begin
        brake_group(1'b0, 1'b0);
        for (int i = 0; i < 4; i++)
          push_update(i, 1'b0, 1'b0, period_q, 1'b0, 1'b0, i == 3);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    errs++;
    if (errs <= 10)
      $display("%0t: update %0d %s: exp ch %0d pins %b%b cmp %0d commit %b hold %b last %b",
               $realtime, updates, what, want.channel, want.in1_level, want.in2_level,
               want.compare_value, want.commit_update, want.hold_period, want.last);
    if (errs <= 10)
      $display("    got ch %0d pins %b%b cmp %0d commit %b hold %b last %b",
               got.channel, got.in1_level, got.in2_level, got.compare_value,
               got.commit_update, got.hold_period, got.last);
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      expected_updates.delete();
      period_q    = PERIOD_RESET;
      invert_mask = '0;
      for (int i = 0; i < 4; i++) chan_dir[i] = DIR_STOP;
      errs    = 0;
      cmds    = 0;
      updates = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PERIOD) begin
          if (cfg_data == '0) period_q = PERIOD_MIN;
          else if (cfg_data > PERIOD_MAX) period_q = PERIOD_MAX;
          else period_q = cfg_data;
        end else begin
          invert_mask = cfg_data[3:0];
        end
      end
      if (out_valid && out_ready) begin
        updates++;
        if (expected_updates.size() == 0) begin
          note_mismatch("with nothing expected", '0, out_data);
        end else begin
          want = expected_updates.pop_front();
          bad  = (want.channel !== out_data.channel) ||
                 (want.in1_level !== out_data.in1_level) ||
                 (want.in2_level !== out_data.in2_level) ||
                 (want.compare_value !== out_data.compare_value) ||
                 (want.commit_update !== out_data.commit_update) ||
                 (want.hold_period !== out_data.hold_period) ||
                 (want.last !== out_data.last);
          if (bad) note_mismatch("wrong", want, out_data);
        end
      end
      if (in_valid && in_ready) begin
        cmds++;
        predict_updates(in_data);
      end
    end
    pending      <= expected_updates.size();
    fail_count   <= errs;
    cmd_count    <= cmds;
    update_count <= updates;
  end

endmodule

[tb/sv/tb_top.sv]
// Stimulus and verdict for the H-bridge drive sequencer. All prediction and
// comparison lives in the checker instantiated beside the block.
module tb_top;
  import hbs_pkg::*;

  localparam int MAX_COMMAND     = 1000;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 43;
  // cycles without any transfer before the run is declared hung; the worst
  // legal stretch is a long sink stall or sender gap plus pipeline latency
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [PERIOD_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cmd_count;
  int update_count;

  // no sink stalls and no sender gaps while set
  bit calm;
  // last sign used per wheel by drive-all, so that repeats keep direction
  int wheel_sign[4];

  h_bridge_pwm_drive_sequencer #(
    .MAX_COMMAND (MAX_COMMAND)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hbs_update_checker #(
    .MAX_COMMAND (MAX_COMMAND)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .cmd_count    (cmd_count),
    .update_count (update_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sink side: mostly ready, short stalls now and then, the odd long one.
  // Changes land on the falling edge so the block sees them settled.
  initial begin
    int hold_off;
    int r;
    hold_off  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          hold_off = $urandom_range(0, 3);
          out_ready <= 1'b0;
        end else if (r < 14) begin
          hold_off = $urandom_range(15, 50);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel resets the count.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("h_bridge_pwm_drive_sequencer regression: fail");
    $finish;
  end

  // Present one command and hold it until the transfer happens. A following
  // call re-drives the payload on the next falling edge with valid still high.
  task automatic send_cmd(input in_item_t cmd);
    @(negedge clk);
    in_data  <= cmd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender gap: valid drops for a stretch set by n; zero means back to back.
  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drop valid, then wait until every predicted update has been seen.
  // Every command yields at least one update, so this means idle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [PERIOD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_sign(input int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 0;
    return ($urandom_range(0, 1) != 0) ? 1 : -1;
  endfunction

  // Speeds weighted towards the useful range, with clamp edges and the
  // most negative code showing up regularly.
  function automatic logic signed [15:0] pick_speed(input int sgn);
    int mag;
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: mag = $urandom_range(1, 1000);
      5, 6:          mag = $urandom_range(1001, 32767);
      7:             mag = 1000;
      8:             mag = 32768;
      default:       mag = $urandom_range(1, 20);
    endcase
    if (sgn == 0) return '0;
    if (sgn > 0) return 16'((mag > 32767) ? 32767 : mag);
    return 16'(-mag);
  endfunction

  function automatic in_item_t mk_cmd(input logic [1:0] act, input int fr, input int rl,
                                      input int fl, input int rr, input int idx,
                                      input int single);
    in_item_t cmd;
    cmd.action            = act;
    cmd.front_right_speed = 16'(fr);
    cmd.rear_left_speed   = 16'(rl);
    cmd.front_left_speed  = 16'(fl);
    cmd.rear_right_speed  = 16'(rr);
    cmd.motor_index       = 2'(idx);
    cmd.single_speed      = 16'(single);
    return cmd;
  endfunction

  // Random command. Fields the action ignores carry random noise. Drive-all
  // often repeats the previous sign pattern so the no-reversal path is hit.
  function automatic in_item_t random_cmd();
    in_item_t cmd;
    int       pick;
    cmd.front_left_speed  = 16'($urandom_range(0, 65535));
    cmd.front_right_speed = 16'($urandom_range(0, 65535));
    cmd.rear_left_speed   = 16'($urandom_range(0, 65535));
    cmd.rear_right_speed  = 16'($urandom_range(0, 65535));
    cmd.motor_index       = 2'($urandom_range(0, 3));
    cmd.single_speed      = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      cmd.action = ACT_DRIVE_ALL;
      if ($urandom_range(0, 9) >= 4)
        for (int i = 0; i < 4; i++) wheel_sign[i] = pick_sign(20);
      cmd.front_right_speed = pick_speed(wheel_sign[0]);
      cmd.rear_left_speed   = pick_speed(wheel_sign[1]);
      cmd.front_left_speed  = pick_speed(wheel_sign[2]);
      cmd.rear_right_speed  = pick_speed(wheel_sign[3]);
    end else if (pick < 75) begin
      cmd.action       = ACT_DRIVE_ONE;
      cmd.single_speed = pick_speed(pick_sign(20));
    end else if (pick < 88) begin
      cmd.action = ACT_BRAKE_ALL;
    end else begin
      cmd.action = ACT_COAST_ALL;
    end
    return cmd;
  endfunction

  // Hand-picked commands at reset settings: each action, no-change and
  // reversal on drive-all, start, hold, reversal and stop on drive-one,
  // clamp edges including the most negative code.
  task automatic run_directed();
    in_item_t cmds[$];
    cmds.push_back(mk_cmd(ACT_DRIVE_ALL, 0, 0, 0, 0, 0, 0));
    cmds.push_back(mk_cmd(ACT_DRIVE_ALL, 500, 500, 500, 500, 0, 0));
    cmds.push_back(mk_cmd(ACT_DRIVE_ALL, 600, 700, 800, 900, 0, 0));
    cmds.push_back(mk_cmd(ACT_DRIVE_ALL, 32767, -32768, 1000, -1000, 0, 0));
    cmds.push_back(mk_cmd(ACT_DRIVE_ALL, -1, 1, 1001, -1001, 0, 0));
    cmds.push_back(mk_cmd(ACT_DRIVE_ALL, -32768, 32767, 32767, -32768, 3, -1));
    cmds.push_back(mk_cmd(ACT_BRAKE_ALL, 0, 0, 0, 0, 0, 0));
    cmds.push_back(mk_cmd(ACT_COAST_ALL, -1, -1, -1, -1, 3, -1));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 0, 300));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 0, 700));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 0, -32768));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 0, 0));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 3, 32767));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 1, -1));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 2, 1000));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 2, 1));
    cmds.push_back(mk_cmd(ACT_DRIVE_ALL, -5, -1, 1, 5, 0, 0));
    cmds.push_back(mk_cmd(ACT_COAST_ALL, 0, 0, 0, 0, 0, 0));
    cmds.push_back(mk_cmd(ACT_DRIVE_ONE, 0, 0, 0, 0, 3, -5));
    cmds.push_back(mk_cmd(ACT_BRAKE_ALL, 32767, -32768, 32767, -32768, 2, 32767));
    foreach (cmds[i]) begin
      send_cmd(cmds[i]);
      idle_sender(pick_gap());
    end
  endtask

  initial begin
    logic [PERIOD_W-1:0] per;
    logic [PERIOD_W-1:0] msk;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PERIOD;
    cfg_data  = '0;
    calm      = 1'b0;
    for (int i = 0; i < 4; i++) wheel_sign[i] = 0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Each phase reprograms both registers once the pipe is empty. The first
    // few hit the period extremes (zero and oversize writes get limited).
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin per = 17'd0;       msk = 17'h0000F; end
        1: begin per = PERIOD_MAX;  msk = 17'h00005; end
        2: begin per = 17'h1FFFF;   msk = 17'h0000A; end
        3: begin per = 17'd1;       msk = 17'h1FFF0; end
        4: begin per = 17'd1000;    msk = 17'h1FFFF; end
        default: begin
          per = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131071))
                                            : 17'($urandom_range(1, 5000));
          msk = 17'($urandom_range(0, 131071));
        end
      endcase
      write_reg(CFG_PERIOD, per);
      write_reg(CFG_SIGN_MASK, msk);
      calm = (p == 1) || (p == 6);
      repeat (ITEMS_PER_PHASE) begin
        send_cmd(random_cmd());
        if (!calm) idle_sender(pick_gap());
      end
    end

    wait_drained();
    // let any stray update surface before judging
    repeat (16) @(posedge clk);

    $display("run covered %0d commands and %0d channel updates across %0d register settings",
             cmd_count, update_count, NUM_PHASES + 1);
    $display("mismatches %0d, updates still outstanding %0d", fail_count, pending);
    if (fail_count == 0 && pending == 0)
      $display("h_bridge_pwm_drive_sequencer regression: pass");
    else
      $display("h_bridge_pwm_drive_sequencer regression: fail");
    $finish;
  end

endmodule
